// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked on every clock edge outside reset
`define AER_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// checked on every clock edge, reset included
`define AER_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`else

`define AER_ASSERT(label, prop)
`define AER_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- rtl/aer_pkg.sv -----
package aer_pkg;

	typedef logic [7:0]   byte_t;
	typedef logic [31:0]  word_t;
	typedef logic [127:0] block_t;
	typedef logic [63:0]  half_t;

	typedef struct packed {
		logic valid;
	} ctrl_t;

	localparam int NUM_COLS = 4;
	localparam int NUM_ROWS = 4;

	localparam byte_t GF_POLY = 8'h1b;

	// register select from paddr[3]
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	localparam byte_t SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// multiply by x in GF(2^8)
	function automatic byte_t xtime(input byte_t v);
		byte_t r;
		r = {v[6:0], 1'b0};
		if (v[7]) begin
			r = r ^ GF_POLY;
		end
		return r;
	endfunction

endpackage

// ----- rtl/aer_column.sv -----
module aer_column import aer_pkg::*; (
	input  logic  clk,
	input  word_t col_in,
	output word_t col_s1
);

	byte_t a0, a1, a2, a3;
	byte_t d0, d1, d2, d3;
	word_t mix;

	always_comb begin
		a0 = SBOX[col_in[31:24]];
		a1 = SBOX[col_in[23:16]];
		a2 = SBOX[col_in[15:8]];
		a3 = SBOX[col_in[7:0]];
		d0 = xtime(a0);
		d1 = xtime(a1);
		d2 = xtime(a2);
		d3 = xtime(a3);
		mix = {d0 ^ d1 ^ a1 ^ a2 ^ a3,
		       a0 ^ d1 ^ d2 ^ a2 ^ a3,
		       a0 ^ a1 ^ d2 ^ d3 ^ a3,
		       d0 ^ a0 ^ a1 ^ a2 ^ d3};
	end

	always_ff @(posedge clk) begin
		col_s1 <= mix;
	end

endmodule

// ----- rtl/aer_merge.sv -----
module aer_merge import aer_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  ctrl_t  ctrl_s1,
	input  block_t mix_s1,
	input  block_t round_key,
	output ctrl_t  ctrl_s2,
	output block_t res_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	// add round key
	always_ff @(posedge clk) begin
		res_s2 <= mix_s1 ^ round_key;
	end

endmodule

// ----- rtl/aes_encrypt_round.sv -----
// channel   | handshake                                   | payload
// ----------+---------------------------------------------+--------------------------
// request   | start, busy (accepted on start && !busy)    | block_high, block_low
// result    | done, one cycle, no back-pressure           | result_high, result_low
// config    | psel, penable, pwrite, pready               | paddr, pwdata, prdata
//
// request to done: sub/shift/mix in four column lanes registered into mix_s1, then key add into res_s2
// a new request is taken every cycle; busy is never raised
// asynchronous active-low reset clears the pipeline valids and both key halves
// the receiver cannot stall, so results leave on done whatever follows
`include "assert_macros.svh"

module aes_encrypt_round import aer_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  half_t       block_high,
	input  half_t       block_low,
	output logic        done,
	output half_t       result_high,
	output half_t       result_low,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	half_t  key_high_q;
	half_t  key_low_q;
	block_t blk;
	block_t mix_s1;
	block_t res_s2;
	ctrl_t  ctrl_s1;
	ctrl_t  ctrl_s2;
	logic   wr_en;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (wr_en) begin
			unique case (paddr[3])
				REG_KEY_HIGH: key_high_q <= pwdata;
				REG_KEY_LOW:  key_low_q  <= pwdata;
				default:      key_high_q <= key_high_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_KEY_HIGH: prdata = key_high_q;
			REG_KEY_LOW:  prdata = key_low_q;
			default:      prdata = '0;
		endcase
	end

	assign blk = {block_high, block_low};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid <= start && !busy;
		end
	end

	// shift rows is wiring: row r of column c comes from column (c+r) mod 4
	for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
		word_t col_in;
		for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
			localparam int SRC = r + NUM_ROWS * ((c + r) % NUM_COLS);
			assign col_in[31 - 8*r -: 8] = blk[127 - 8*SRC -: 8];
		end
		aer_column u_column (
			.clk    (clk),
			.col_in (col_in),
			.col_s1 (mix_s1[127 - 32*c -: 32])
		);
	end

	aer_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s1   (ctrl_s1),
		.mix_s1    (mix_s1),
		.round_key ({key_high_q, key_low_q}),
		.ctrl_s2   (ctrl_s2),
		.res_s2    (res_s2)
	);

	assign done        = ctrl_s2.valid;
	assign result_high = res_s2[127:64];
	assign result_low  = res_s2[63:0];

	`AER_ASSERT(a_req_gives_done, start && !busy |-> ##2 done)
	`AER_ASSERT(a_done_has_req, done |-> $past(start && !busy, 2))
	`AER_ASSERT(a_key_high_write, wr_en && paddr[3] == REG_KEY_HIGH |=> key_high_q == $past(pwdata))
	`AER_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import aer_pkg::*;

	localparam logic [3:0] ADDR_KEY_HIGH = {REG_KEY_HIGH, 3'b000};
	localparam logic [3:0] ADDR_KEY_LOW  = {REG_KEY_LOW, 3'b000};
	localparam int FLUSH_CYCLES = 4;

	typedef struct packed {
		half_t high;
		half_t low;
	} round_out_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	half_t       block_high;
	half_t       block_low;
	logic        done;
	half_t       result_high;
	half_t       result_low;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	byte_t       sub_lut [256];
	half_t       key_high;
	half_t       key_low;
	round_out_t  pending_rounds [$];
	round_out_t  oldest_round;
	int unsigned errors;
	int unsigned blocks_sent;
	int unsigned rounds_checked;
	int unsigned key_writes;
	int unsigned burst_left;

	aes_encrypt_round i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.block_high  (block_high),
		.block_low   (block_low),
		.done        (done),
		.result_high (result_high),
		.result_low  (result_low),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic byte_t gf_double(input byte_t v);
		return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
	endfunction

	function automatic byte_t gf_mul(input byte_t a, input byte_t b);
		byte_t acc;
		byte_t p;
		acc = 8'h00;
		p = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ p;
			end
			p = gf_double(p);
		end
		return acc;
	endfunction

	function automatic byte_t rotl8(input byte_t v, input int n);
		return byte_t'((v << n) | (v >> (8 - n)));
	endfunction

	// one full middle round, column-major state
	function automatic round_out_t encrypt_round(input half_t hi, input half_t lo,
			input half_t khi, input half_t klo);
		byte_t st [16];
		byte_t sh [16];
		byte_t kb [16];
		byte_t mixed [16];
		byte_t a0, a1, a2, a3, d0, d1, d2, d3;
		round_out_t r;
		for (int i = 0; i < 8; i++) begin
			st[i]     = hi[63 - 8 * i -: 8];
			st[i + 8] = lo[63 - 8 * i -: 8];
			kb[i]     = khi[63 - 8 * i -: 8];
			kb[i + 8] = klo[63 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int rw = 0; rw < 4; rw++) begin
				sh[rw + 4 * c] = sub_lut[st[rw + 4 * ((c + rw) % 4)]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = sh[4 * c];
			a1 = sh[4 * c + 1];
			a2 = sh[4 * c + 2];
			a3 = sh[4 * c + 3];
			d0 = gf_double(a0);
			d1 = gf_double(a1);
			d2 = gf_double(a2);
			d3 = gf_double(a3);
			mixed[4 * c]     = d0 ^ d1 ^ a1 ^ a2 ^ a3;
			mixed[4 * c + 1] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
			mixed[4 * c + 2] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
			mixed[4 * c + 3] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
		end
		for (int i = 0; i < 8; i++) begin
			r.high[63 - 8 * i -: 8] = mixed[i] ^ kb[i];
			r.low[63 - 8 * i -: 8]  = mixed[i + 8] ^ kb[i + 8];
		end
		return r;
	endfunction

	function automatic half_t random_half();
		half_t v;
		case ($urandom_range(0, 11))
			0: v = '0;
			1: v = '1;
			2: v = half_t'(64'h1) << $urandom_range(0, 63);
			3: v = ~(half_t'(64'h1) << $urandom_range(0, 63));
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rounds.size() == 0) begin
				$error("round result with no request outstanding: %h %h",
					result_high, result_low);
				errors++;
			end else begin
				oldest_round = pending_rounds.pop_front();
				rounds_checked++;
				if (result_high !== oldest_round.high) begin
					$error("result_high expected %h actual %h", oldest_round.high, result_high);
					errors++;
				end
				if (result_low !== oldest_round.low) begin
					$error("result_low expected %h actual %h", oldest_round.low, result_low);
					errors++;
				end
			end
		end
	end

	task automatic send_block(input half_t hi, input half_t lo);
		start <= 1'b1;
		block_high <= hi;
		block_low <= lo;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_rounds.push_back(encrypt_round(hi, lo, key_high, key_low));
		blocks_sent++;
	endtask

	task automatic pause_for_results();
		start <= 1'b0;
		while (pending_rounds.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	task automatic write_key(input logic [3:0] addr, input half_t value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (addr == ADDR_KEY_HIGH) begin
			key_high = value;
		end else begin
			key_low = value;
		end
		key_writes++;
	endtask

	task automatic set_round_key(input half_t hi, input half_t lo);
		pause_for_results();
		if ($urandom_range(0, 1)) begin
			write_key(ADDR_KEY_LOW, lo);
			write_key(ADDR_KEY_HIGH, hi);
		end else begin
			write_key(ADDR_KEY_HIGH, hi);
			write_key(ADDR_KEY_LOW, lo);
		end
	endtask

	// bursts of requests with random gaps, now and then waiting for all results
	task automatic send_stream(input int n);
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				start <= 1'b0;
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(9, 30)) @(posedge clk);
				end else begin
					repeat ($urandom_range(1, 5)) @(posedge clk);
				end
				burst_left = $urandom_range(1, 48);
			end
			if ($urandom_range(0, 299) == 0) begin
				pause_for_results();
			end
			send_block(random_half(), random_half());
			burst_left--;
		end
	endtask

	task automatic test_reset_key();
		half_t walk;
		send_block('0, '0);
		send_block('1, '1);
		send_block({16{4'ha}}, {16{4'h5}});
		send_block({16{4'h5}}, {16{4'ha}});
		for (int i = 0; i < 8; i++) begin
			walk = half_t'(64'hff) << (8 * i);
			send_block(walk, ~walk);
		end
		pause_for_results();
	endtask

	task automatic test_known_round();
		set_round_key(64'ha0fafe1788542cb1, 64'h23a339392a6c7605);
		send_block(64'h193de3bea0f4e22b, 64'h9ac68d2ae9f84808);
		send_block('1, '0);
		pause_for_results();
	endtask

	task automatic test_key_extremes();
		set_round_key('1, '1);
		send_block('0, '0);
		send_block('1, '1);
		set_round_key('1, '0);
		send_block({$urandom, $urandom}, {$urandom, $urandom});
		set_round_key({16{4'ha}}, {16{4'h5}});
		send_block('0, '1);
		pause_for_results();
	endtask

	task automatic test_full_rate();
		for (int i = 0; i < 100; i++) begin
			send_block(random_half(), random_half());
		end
		pause_for_results();
	endtask

	task automatic test_random_rounds();
		half_t khi;
		half_t klo;
		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0: begin khi = '1; klo = '1; end
				1: begin khi = '0; klo = '0; end
				2: begin khi = '1; klo = '0; end
				3: begin khi = '0; klo = '1; end
				default: begin khi = random_half(); klo = random_half(); end
			endcase
			set_round_key(khi, klo);
			burst_left = 0;
			send_stream($urandom_range(130, 170));
		end
		pause_for_results();
	endtask

	initial begin
		byte_t inv;
		errors = 0;
		blocks_sent = 0;
		rounds_checked = 0;
		key_writes = 0;
		burst_left = 0;
		key_high = '0;
		key_low = '0;
		arst_n = 1'b0;
		start = 1'b0;
		block_high = '0;
		block_low = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// substitution table from field inverse and affine map
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++) begin
				if (gf_mul(byte_t'(x), byte_t'(y)) == 8'h01) begin
					inv = byte_t'(y);
				end
			end
			sub_lut[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
				^ 8'h63;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_known_round();
		test_key_extremes();
		test_full_rate();
		test_random_rounds();

		pause_for_results();
		repeat (8) @(posedge clk);
		$display("covered %0d round requests and %0d checked results", blocks_sent,
			rounds_checked);
		$display("over %0d key register writes, extremes and random keys", key_writes);
		if (errors == 0 && pending_rounds.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
